// ----- rtl/core/mdse_pkg.sv -----
`timescale 1ns / 1ps
package mdse_pkg;
   localparam int MaxDimDefault = 16;
   localparam int IdxWidth      = 5;
   localparam int DataWidth     = 32;

   typedef enum logic [2:0] {
      OP_WRITE = 3'd0,
      OP_READ  = 3'd1,
      OP_CPOS  = 3'd2,
      OP_MANTI = 3'd3,
      OP_MUPP  = 3'd4,
      OP_SWAP  = 3'd5,
      OP_SORT  = 3'd6,
      OP_NONE  = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_A, ST_WAIT_A, ST_RD_B, ST_WAIT_B, ST_EVAL, ST_WR_A, ST_WR_B, ST_DONE
   } state_type;

   // Compare result handed from the shared compare unit to the sequencer
   typedef struct packed {
      logic less;
      logic pos;
   } cmp_type;
endpackage

// ----- rtl/core/matrix_diagonal_sort_engine.sv -----
`timescale 1ns / 1ps
// Square matrix engine: a single-port store of MAX_DIM*MAX_DIM signed words
// and a sequencer that drives one shared signed comparator. One item is taken
// at a time and req_tready stays low until its result has been transferred.
// A write goes from acceptance straight to its store write; a read issues the
// address, waits for the registered data and evaluates it; an out-of-range
// item or the unused code goes straight to the response. A row swap reads
// both words of each column, evaluates and writes both back; the diagonal,
// anti-diagonal and upper-triangle scans read and evaluate one element at a
// time; a column sort reads and compares each pair and writes it back only
// when exchanged, over n(n-1)/2 compare steps. The single read port sets this.
module matrix_diagonal_sort_engine
   import mdse_pkg::*;
#(
   parameter int MAX_DIM = MaxDimDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] opcode, [7:3] row_index, [12:8] col_index, [17:13] second_row,
   // [49:18] write_value, [55:50] zero
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] result_value, [36:32] min_row, [41:37] min_col, [42] range_error,
   // [47:43] zero
   output logic [47:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);
   localparam int AW    = $clog2(MAX_DIM);
   localparam int MW    = 2 * AW;
   localparam int DEPTH = 2 ** MW;

   logic [4:0] size_ff;
   logic [AW:0] n;
   state_type state_ff, state_in;
   op_type op_ff, op_in;
   logic [AW:0] ra_ff, ra_in, rb_ff, rb_in, i_ff, i_in, j_ff, j_in;
   logic [AW-1:0] col_ff, col_in;
   logic signed [DataWidth-1:0] wv_ff, wv_in, va_ff, va_in, vb_ff, vb_in;
   logic signed [DataWidth-1:0] best_ff, best_in;
   logic [AW:0] br_ff, br_in, bc_ff, bc_in;
   logic err_ff, err_in;
   logic [DataWidth-1:0] res_ff, res_in;
   logic out_v_ff, out_v_in;
   logic first_ff, first_in;

   logic signed [DataWidth-1:0] mem [DEPTH];
   logic signed [DataWidth-1:0] rd_ff;
   logic [MW-1:0] addr;
   logic          we;
   logic signed [DataWidth-1:0] wdata;
   logic [AW-1:0] ar, ac;
   cmp_type cres;
   logic signed [DataWidth-1:0] ca_op, cb_op;

   // Clamp size in use to 1..MAX_DIM
   always_comb begin
      if (size_ff == 5'd0) n = (AW+1)'(1);
      else if (32'(size_ff) > MAX_DIM) n = (AW+1)'(MAX_DIM);
      else n = (AW+1)'(size_ff);
   end

   assign csr_ready = (state_ff == ST_IDLE) && !out_v_ff;
   always_ff @(posedge clock) begin
      if (reset) size_ff <= 5'd1;
      else if (csr_valid && csr_ready) size_ff <= csr_data;
   end

   // Single-port store, registered read
   assign addr = {ar, ac};
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rd_ff <= mem[addr];
   end

   mdse_cmp u_cmp (.a(ca_op), .b(cb_op), .res(cres));

   assign req_tready = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {5'd0, err_ff, 5'(bc_ff), 5'(br_ff), res_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
      op_ff <= op_in; ra_ff <= ra_in; rb_ff <= rb_in; i_ff <= i_in; j_ff <= j_in;
      col_ff <= col_in; wv_ff <= wv_in; va_ff <= va_in; vb_ff <= vb_in;
      best_ff <= best_in; br_ff <= br_in; bc_ff <= bc_in; err_ff <= err_in;
      res_ff <= res_in; first_ff <= first_in;
   end

   // Sequencer
   always_comb begin
      logic [2:0] rop;
      logic [4:0] r5, c5, s5;
      logic take;
      state_in = state_ff; op_in = op_ff; ra_in = ra_ff; rb_in = rb_ff;
      i_in = i_ff; j_in = j_ff; col_in = col_ff; wv_in = wv_ff;
      va_in = va_ff; vb_in = vb_ff; best_in = best_ff; br_in = br_ff;
      bc_in = bc_ff; err_in = err_ff; res_in = res_ff; out_v_in = out_v_ff;
      first_in = first_ff;
      take = 1'b0;
      ar = '0; ac = '0; we = 1'b0; wdata = va_ff;
      ca_op = va_ff; cb_op = vb_ff;
      rop = req_tdata[2:0]; r5 = req_tdata[7:3]; c5 = req_tdata[12:8];
      s5 = req_tdata[17:13];
      if (out_v_ff && rsp_tready) out_v_in = 1'b0;

      // Addresses for the pair under work
      unique case (op_ff)
         OP_WRITE, OP_READ: begin ar = AW'(ra_ff); ac = AW'(j_ff); end
         OP_CPOS: begin ar = AW'(i_ff); ac = AW'(i_ff); end
         OP_MANTI: begin ar = AW'(i_ff); ac = AW'(n - 1 - i_ff); end
         OP_MUPP: begin ar = AW'(i_ff); ac = AW'(j_ff); end
         OP_SWAP: begin
            ar = (state_ff == ST_RD_B || state_ff == ST_WR_A) ? AW'(rb_ff) : AW'(ra_ff);
            ac = AW'(j_ff);
            if (state_ff == ST_WR_A) ar = AW'(ra_ff);
            if (state_ff == ST_WR_B) ar = AW'(rb_ff);
         end
         OP_SORT: begin
            ar = (state_ff == ST_RD_B || state_ff == ST_WR_B) ? AW'(j_ff + 1) : AW'(j_ff);
            ac = col_ff;
         end
         default: begin ar = '0; ac = '0; end
      endcase

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in = op_type'(rop); wv_in = req_tdata[49:18];
               err_in = 1'b0; res_in = '0; br_in = '0; bc_in = '0;
               i_in = '0; j_in = '0; first_in = 1'b1;
               ra_in = (AW+1)'(r5); rb_in = (AW+1)'(s5);
               col_in = AW'(c5 - 5'd1);
               state_in = ST_RD_A;
               unique case (op_type'(rop))
                  OP_WRITE, OP_READ: begin
                     j_in = (AW+1)'(c5);
                     if (32'(r5) >= 32'(n) || 32'(c5) >= 32'(n)) begin
                        err_in = 1'b1; state_in = ST_DONE;
                     end else if (op_type'(rop) == OP_WRITE) state_in = ST_WR_A;
                  end
                  OP_SWAP: begin
                     ra_in = (AW+1)'(r5 - 5'd1); rb_in = (AW+1)'(s5 - 5'd1);
                     if (r5 == 5'd0 || 32'(r5) > 32'(n) ||
                         s5 == 5'd0 || 32'(s5) > 32'(n)) begin
                        err_in = 1'b1; state_in = ST_DONE;
                     end
                  end
                  OP_SORT: begin
                     i_in = n - 1'b1;
                     if (c5 == 5'd0 || 32'(c5) > 32'(n)) begin
                        err_in = 1'b1; state_in = ST_DONE;
                     end else if (n == 1) state_in = ST_DONE;
                  end
                  OP_NONE: state_in = ST_DONE;
                  default: ;
               endcase
            end
         end
         ST_RD_A: state_in = ST_WAIT_A;
         ST_WAIT_A: begin
            va_in = rd_ff;
            if (op_ff == OP_SWAP || op_ff == OP_SORT) state_in = ST_RD_B;
            else state_in = ST_EVAL;
         end
         ST_RD_B: state_in = ST_WAIT_B;
         ST_WAIT_B: begin vb_in = rd_ff; state_in = ST_EVAL; end
         ST_EVAL: begin
            state_in = ST_RD_A;
            unique case (op_ff)
               OP_READ: begin res_in = va_ff; state_in = ST_DONE; end
               OP_CPOS: begin
                  if (cres.pos) res_in = res_ff + 1'b1;
                  i_in = i_ff + 1'b1;
                  if (i_ff + 1'b1 == n) state_in = ST_DONE;
               end
               OP_MANTI: begin
                  cb_op = best_ff;
                  if (first_ff || cres.less) best_in = va_ff;
                  first_in = 1'b0;
                  i_in = i_ff + 1'b1;
                  if (i_ff + 1'b1 == n) begin
                     res_in = (first_ff || cres.less) ? va_ff : best_ff;
                     state_in = ST_DONE;
                  end
               end
               OP_MUPP: begin
                  cb_op = best_ff;
                  take = first_ff || cres.less;
                  if (take) begin best_in = va_ff; br_in = i_ff; bc_in = j_ff; end
                  first_in = 1'b0;
                  if (j_ff + 1'b1 == n) begin
                     i_in = i_ff + 1'b1; j_in = i_ff + 1'b1;
                     if (i_ff + 1'b1 == n) begin
                        res_in = take ? va_ff : best_ff;
                        br_in = (take ? i_ff : br_ff) + 1'b1;
                        bc_in = (take ? j_ff : bc_ff) + 1'b1;
                        state_in = ST_DONE;
                     end
                  end else j_in = j_ff + 1'b1;
               end
               OP_SWAP: state_in = ST_WR_A;
               OP_SORT: begin
                  ca_op = vb_ff; cb_op = va_ff;
                  if (cres.less) state_in = ST_WR_A;
                  else if (j_ff + 1'b1 == i_ff) begin
                     j_in = '0; i_in = i_ff - 1'b1;
                     if (i_ff == 1) state_in = ST_DONE;
                  end else j_in = j_ff + 1'b1;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_WR_A: begin
            we = 1'b1;
            if (op_ff == OP_WRITE) begin
               wdata = wv_ff; state_in = ST_DONE;
            end else begin
               wdata = (op_ff == OP_SWAP) ? va_ff : vb_ff;
               if (op_ff == OP_SWAP) wdata = vb_ff;
               state_in = ST_WR_B;
            end
         end
         ST_WR_B: begin
            we = 1'b1; wdata = va_ff;
            state_in = ST_RD_A;
            if (op_ff == OP_SWAP) begin
               j_in = j_ff + 1'b1;
               if (j_ff + 1'b1 == n) state_in = ST_DONE;
            end else if (j_ff + 1'b1 == i_ff) begin
               j_in = '0; i_in = i_ff - 1'b1;
               if (i_ff == 1) state_in = ST_DONE;
            end else j_in = j_ff + 1'b1;
         end
         ST_DONE: begin out_v_in = 1'b1; state_in = ST_IDLE; end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ----- rtl/core/mdse_cmp.sv -----
`timescale 1ns / 1ps
module mdse_cmp
   import mdse_pkg::*;
(
   input  logic signed [DataWidth-1:0] a,
   input  logic signed [DataWidth-1:0] b,
   output cmp_type                     res
);
   // Signed compare shared by every scan and sort step
   assign res.less = (a < b);
   assign res.pos  = (a > 0);
endmodule
